/* src/websocket_frame_decoder_macros.svh */
// Assertion macros shared by the frame decoder modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef WEBSOCKET_FRAME_DECODER_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WSFD_ASSERT_NOW(lbl, ante, cons, msg)
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/wsfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  // Width of the payload length counter; longer lengths saturate.
  localparam int LEN_BITS = 64;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One result request passed from the parser to the output stage.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       has_data;
    logic       frame_end;
    logic       pong;
    logic       closed;
  } tok_t;

endpackage

`default_nettype wire

/* src/wsfd_channels.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] frame_opcode;
  logic       has_data;
  logic       frame_end;
  logic       pong_reply;
  logic       link_closed;

  modport source (output valid, output data_byte, output frame_opcode, output has_data,
                  output frame_end, output pong_reply, output link_closed, input ready);
  modport sink (input valid, input data_byte, input frame_opcode, input has_data,
                input frame_end, input pong_reply, input link_closed, output ready);
endinterface

`default_nettype wire

/* src/websocket_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Receive-side WebSocket frame decoder.
// The in_if channel takes one received byte per request; the out_if channel
// gives at most one result per input byte: an unmasked payload byte with its
// opcode, an empty-frame marker, or the single close result.
// Both channels use valid/ready; a request moves when both are high.
// Throughput is one byte per cycle while the request queue is not full: the
// header parser updates its state and classifies each byte in the cycle it is accepted.
// A result passes through the four-entry request queue and then the output
// register, where the mask XOR is applied; out_if.valid comes from that
// register.
// When the receiver stalls, results collect in the queue; in_if.ready drops
// only once all four entries are full, and no result is lost.
// Reset (rst_n low, synchronous) returns the parser to the first header byte,
// reopens the link and empties the queue and output register.
// After a close frame every later byte is accepted and dropped until reset.

module websocket_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  wsfd_in_if.sink     in_if,
  wsfd_out_if.source  out_if
);
  import wsfd_pkg::*;

  logic in_ready;
  logic q_full;
  logic push;
  tok_t push_tok;
  logic pop_valid;
  logic pop_ready;
  tok_t pop_tok;

  assign in_if.ready = in_ready;

  wsfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_if.valid),
    .in_byte_i  (in_if.rx_byte),
    .in_ready_o (in_ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .tok_o      (push_tok)
  );

  wsfd_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_tok_i  (push_tok),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_tok_o   (pop_tok)
  );

  wsfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_tok_i      (pop_tok),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .data_byte_o    (out_if.data_byte),
    .frame_opcode_o (out_if.frame_opcode),
    .has_data_o     (out_if.has_data),
    .frame_end_o    (out_if.frame_end),
    .pong_reply_o   (out_if.pong_reply),
    .link_closed_o  (out_if.link_closed)
  );

endmodule

`default_nettype wire

/* src/wsfd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_decoder_macros.svh"

module wsfd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output logic          push_o,
  output wsfd_pkg::tok_t tok_o
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          opcode_r, opcode_nxt;
  logic                mask_on_r, mask_on_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]          hcnt_r, hcnt_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [1:0]          mpos_r, mpos_nxt;

  logic                accept;
  logic                len_done;
  logic                hdr_done;
  logic                len_zero;
  logic                push;
  tok_t                tok;
  logic [6:0]          len7;
  logic [LEN_BITS-1:0] rem_shift;
  logic [7:0]          key_byte;
  logic                last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len7       = in_byte_i[6:0];
  assign last       = (rem_r == {{(LEN_BITS-1){1'b0}}, 1'b1});

  // A length byte that would overflow the counter pins it at all ones.
  assign rem_shift = (rem_r[LEN_BITS-1 -: 8] != 8'd0) ? {LEN_BITS{1'b1}}
                                                       : {rem_r[LEN_BITS-9:0], in_byte_i};

  always_comb begin
    unique case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    opcode_nxt  = opcode_r;
    mask_on_nxt = mask_on_r;
    rem_nxt     = rem_r;
    hcnt_nxt    = hcnt_r;
    key_nxt     = key_r;
    mpos_nxt    = mpos_r;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    len_zero    = 1'b0;
    push        = 1'b0;
    tok         = '0;
    tok.opcode  = opcode_r;

    unique case (phase_r)
      PH_HDR0: begin
        opcode_nxt = in_byte_i[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_nxt = in_byte_i[7];
        rem_nxt     = '0;
        if (len7 == LEN7_EXT16) begin
          hcnt_nxt  = 3'd1;
          phase_nxt = PH_EXT;
        end else if (len7 == LEN7_EXT64) begin
          hcnt_nxt  = 3'd7;
          phase_nxt = PH_EXT;
        end else begin
          rem_nxt  = {{(LEN_BITS-7){1'b0}}, len7};
          len_done = 1'b1;
          len_zero = (len7 == 7'd0);
        end
      end
      PH_EXT: begin
        rem_nxt = rem_shift;
        if (hcnt_r == 3'd0) begin
          len_done = 1'b1;
          len_zero = (rem_shift == '0);
        end else begin
          hcnt_nxt = hcnt_r - 3'd1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], in_byte_i};
        if (hcnt_r == 3'd0) begin
          hdr_done = 1'b1;
          len_zero = (rem_r == '0);
        end else begin
          hcnt_nxt = hcnt_r - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        mpos_nxt = mpos_r + 2'd1;
        rem_nxt  = rem_r - {{(LEN_BITS-1){1'b0}}, 1'b1};
        if (last) begin
          phase_nxt = PH_HDR0;
        end
        if (opcode_r == OP_CLOSE) begin
          if (last) begin
            push       = 1'b1;
            tok.closed = 1'b1;
            tok.frame_end = 1'b1;
            phase_nxt  = PH_CLOSED;
          end
        end else if (opcode_r != OP_PONG) begin
          push          = 1'b1;
          tok.raw       = in_byte_i;
          tok.key       = mask_on_r ? key_byte : 8'd0;
          tok.has_data  = 1'b1;
          tok.frame_end = last;
          tok.pong      = (opcode_r == OP_PING);
        end
      end
      default: begin
        phase_nxt = PH_CLOSED;
      end
    endcase

    if (len_done) begin
      if (mask_on_nxt) begin
        key_nxt   = '0;
        hcnt_nxt  = 3'd3;
        phase_nxt = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      mpos_nxt = 2'd0;
      if (!len_zero) begin
        phase_nxt = PH_PAYLOAD;
      end else begin
        phase_nxt = PH_HDR0;
        if (opcode_r == OP_CLOSE) begin
          push          = 1'b1;
          tok.closed    = 1'b1;
          tok.frame_end = 1'b1;
          phase_nxt     = PH_CLOSED;
        end else if (opcode_r != OP_PONG) begin
          push          = 1'b1;
          tok.frame_end = 1'b1;
          tok.pong      = (opcode_r == OP_PING);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      opcode_r  <= 4'd0;
      mask_on_r <= 1'b0;
      rem_r     <= '0;
      hcnt_r    <= 3'd0;
      key_r     <= 32'd0;
      mpos_r    <= 2'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      mask_on_r <= mask_on_nxt;
      rem_r     <= rem_nxt;
      hcnt_r    <= hcnt_nxt;
      key_r     <= key_nxt;
      mpos_r    <= mpos_nxt;
    end
  end

  assign push_o = accept && push;
  assign tok_o  = tok;

  `WSFD_ASSERT_NEXT(a_closed_sticky, phase_r == PH_CLOSED, phase_r == PH_CLOSED,
                    "link came back after close")
  `WSFD_ASSERT_NOW(a_close_ends_frame, push_o && tok_o.closed,
                   tok_o.frame_end && !tok_o.has_data, "close request malformed")

endmodule

`default_nettype wire

/* src/wsfd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_decoder_macros.svh"

module wsfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  wsfd_pkg::tok_t push_tok_i,
  output logic           full_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output wsfd_pkg::tok_t pop_tok_o
);
  import wsfd_pkg::*;

  tok_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               pop;

  assign full_o      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign pop_valid_o = (cnt_r != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_tok_o   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= push_tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push_i) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  `WSFD_ASSERT_NOW(a_no_push_when_full, push_i, !full_o, "request written into full queue")

endmodule

`default_nettype wire

/* src/wsfd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_decoder_macros.svh"

module wsfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  wsfd_pkg::tok_t pop_tok_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     data_byte_o,
  output logic [3:0]     frame_opcode_o,
  output logic           has_data_o,
  output logic           frame_end_o,
  output logic           pong_reply_o,
  output logic           link_closed_o
);
  import wsfd_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic [3:0] opcode_r;
  logic       has_data_r;
  logic       frame_end_r;
  logic       pong_r;
  logic       closed_r;
  logic       load;

  // The output register refills whenever it is empty or being taken.
  assign pop_ready_o = !valid_r || out_ready_i;
  assign load        = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready_o) begin
      valid_r <= pop_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r      <= pop_tok_i.has_data ? (pop_tok_i.raw ^ pop_tok_i.key) : 8'd0;
      opcode_r    <= pop_tok_i.opcode;
      has_data_r  <= pop_tok_i.has_data;
      frame_end_r <= pop_tok_i.frame_end;
      pong_r      <= pop_tok_i.pong;
      closed_r    <= pop_tok_i.closed;
    end
  end

  assign out_valid_o    = valid_r;
  assign data_byte_o    = data_r;
  assign frame_opcode_o = opcode_r;
  assign has_data_o     = has_data_r;
  assign frame_end_o    = frame_end_r;
  assign pong_reply_o   = pong_r;
  assign link_closed_o  = closed_r;

  `WSFD_ASSERT_NOW(a_empty_data_zero, valid_r && !has_data_r, data_r == 8'd0,
                   "nonzero data on an empty result")

endmodule

`default_nettype wire

/* tb/wsfd_stream_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the frame decoder. It tracks the frame parse for
// every accepted byte and compares every accepted result with the oldest
// result still owed.
module wsfd_stream_checker
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wsfd_in_if         in_ch,
  wsfd_out_if        out_ch,
  output int         results_owed,
  output int         results_checked,
  output int         fail_count
);

  typedef enum logic [2:0] {
    HDR_OPCODE, HDR_LEN, HDR_EXTLEN, HDR_KEY, BODY, LINK_DOWN
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       has_data;
    logic       frame_end;
    logic       pong;
    logic       closed;
  } frame_result_t;

  frame_result_t          owed_results[$];
  parse_phase_e           phase;
  logic [3:0]             opcode;
  logic                   masked;
  logic [LEN_BITS-1:0]    len_left;
  logic [2:0]             hdr_left;
  logic [31:0]            mask_key;
  logic [1:0]             key_pos;
  int                     n_checked;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count < 30) begin
      $display("[%0t] mismatch on %s at result %0d: got %h, want %h",
               $time, what, n_checked, got, want);
    end
    fail_count++;
  endtask

  task automatic emit_result(input logic [7:0] data, input logic has_data,
                             input logic frame_end, input logic pong, input logic closed);
    frame_result_t r;
    r.data      = data;
    r.opcode    = opcode;
    r.has_data  = has_data;
    r.frame_end = frame_end;
    r.pong      = pong;
    r.closed    = closed;
    owed_results.push_back(r);
  endtask

  task automatic emit_close();
    emit_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
    phase = LINK_DOWN;
  endtask

  task automatic end_of_header();
    key_pos = '0;
    if (len_left != '0) begin
      phase = BODY;
    end else begin
      phase = HDR_OPCODE;
      if (opcode == OP_CLOSE) begin
        emit_close();
      end else if (opcode != OP_PONG) begin
        emit_result(8'h00, 1'b0, 1'b1, opcode == OP_PING, 1'b0);
      end
    end
  endtask

  task automatic end_of_length();
    if (masked) begin
      mask_key = '0;
      hdr_left = 3'd3;
      phase = HDR_KEY;
    end else begin
      end_of_header();
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    logic       last;
    case (phase)
      HDR_OPCODE: begin
        opcode = b[3:0];
        phase = HDR_LEN;
      end
      HDR_LEN: begin
        masked = b[7];
        len_left = '0;
        if (b[6:0] == LEN7_EXT16) begin
          hdr_left = 3'd1;
          phase = HDR_EXTLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          hdr_left = 3'd7;
          phase = HDR_EXTLEN;
        end else begin
          len_left = LEN_BITS'(b[6:0]);
          end_of_length();
        end
      end
      HDR_EXTLEN: begin
        // A length that no longer fits the counter sticks at all ones.
        if (len_left[LEN_BITS-1 -: 8] != '0) len_left = '1;
        else len_left = {len_left[LEN_BITS-9:0], b};
        if (hdr_left == '0) end_of_length();
        else hdr_left--;
      end
      HDR_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (hdr_left == '0) end_of_header();
        else hdr_left--;
      end
      BODY: begin
        key_byte = masked ? 8'(mask_key >> (24 - 8 * key_pos)) : 8'h00;
        key_pos = key_pos + 2'd1;
        len_left = len_left - 1'b1;
        last = (len_left == '0);
        if (last) phase = HDR_OPCODE;
        if (opcode == OP_CLOSE) begin
          if (last) emit_close();
        end else if (opcode != OP_PONG) begin
          emit_result(b ^ key_byte, 1'b1, last, opcode == OP_PING, 1'b0);
        end
      end
      default: phase = LINK_DOWN;
    endcase
  endtask

  task automatic match_result();
    frame_result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("unexpected result, data_byte", out_ch.data_byte, 8'h00);
      return;
    end
    want = owed_results.pop_front();
    n_checked++;
    if (out_ch.data_byte !== want.data)
      report_mismatch("data_byte", out_ch.data_byte, want.data);
    if (out_ch.frame_opcode !== want.opcode)
      report_mismatch("frame_opcode", out_ch.frame_opcode, want.opcode);
    if (out_ch.has_data !== want.has_data)
      report_mismatch("has_data", out_ch.has_data, want.has_data);
    if (out_ch.frame_end !== want.frame_end)
      report_mismatch("frame_end", out_ch.frame_end, want.frame_end);
    if (out_ch.pong_reply !== want.pong)
      report_mismatch("pong_reply", out_ch.pong_reply, want.pong);
    if (out_ch.link_closed !== want.closed)
      report_mismatch("link_closed", out_ch.link_closed, want.closed);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = HDR_OPCODE;
      opcode = '0;
      masked = 1'b0;
      len_left = '0;
      hdr_left = '0;
      mask_key = '0;
      key_pos = '0;
      owed_results.delete();
    end else begin
      // A result leaving at this edge belongs to an earlier byte, so match first.
      if (out_ch.valid && out_ch.ready) match_result();
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.rx_byte);
    end
    results_owed <= owed_results.size();
    results_checked <= n_checked;
  end

endmodule

/* tb/websocket_frame_decoder_tb.sv */
`timescale 1ns / 1ps

module websocket_frame_decoder_tb;
  import wsfd_pkg::*;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;
  typedef enum int {END_EMPTY_CLOSE, END_CLOSE_WITH_BODY, END_OPEN_FRAME} stream_tail_e;

  localparam int GAP_TAB[4]   = '{0, 70, 0, 29};
  localparam int STALL_TAB[4] = '{0, 0, 70, 29};
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_BYTES  = 190;

  logic clk = 1'b0;
  logic rst_n;

  int gap_pct;
  int stall_pct;
  int hold_ask;
  bit counting;
  int useful_bytes;
  int total_bytes;
  int frames_sent;
  int results_owed;
  int results_checked;
  int fail_count;

  wsfd_in_if  in_if();
  wsfd_out_if out_if();

  websocket_frame_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  wsfd_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .results_owed    (results_owed),
    .results_checked (results_checked),
    .fail_count      (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    total_bytes++;
    if (counting) useful_bytes++;
  endtask

  task automatic send_frame(input logic [3:0] flags, input logic [3:0] op, input logic masked,
                            input len_form_e form, input logic [63:0] len, input int body);
    logic [31:0] key;
    key = $urandom;
    frames_sent++;
    // Pong bytes are swallowed whole, so they do not count toward the stimulus size.
    counting = (op != OP_PONG);
    send_byte({flags, op});
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (int i = 0; i < body; i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    logic [3:0]  op;
    logic [63:0] len;
    len_form_e   form;
    int          pick;
    op = 4'($urandom_range(14));
    if (op >= OP_CLOSE) op = op + 4'd1;
    pick = $urandom_range(99);
    if (pick < 15) op = OP_PING;
    else if (pick < 27) op = OP_PONG;
    pick = $urandom_range(99);
    if (pick < 78) begin
      form = LEN_SHORT;
      len = (pick < 8) ? 64'd0 : (pick < 10) ? 64'd125 : 64'($urandom_range(12, 1));
    end else if (pick < 90) begin
      form = LEN_EXT16;
      len = (pick < 82) ? 64'd0 : (pick == 83) ? 64'($urandom_range(300, 256))
                                               : 64'($urandom_range(40));
    end else begin
      form = LEN_EXT64;
      len = 64'($urandom_range(20));
    end
    send_frame(4'($urandom), op, 1'($urandom), form, len, int'(len));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin
    stream_tail_e tail;
    logic [63:0]  huge_len;
    int           target;

    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    gap_pct = 0;
    stall_pct = 0;
    hold_ask = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ping and pong, an empty frame through the 16-bit length, a masked
    // text frame with all flag bits set, a masked ping and a reserved opcode.
    send_frame(4'h8, OP_PING, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame(4'h8, OP_PONG, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame(4'h0, 4'h2, 1'b0, LEN_EXT16, 64'd0, 0);
    send_frame(4'hF, 4'h1, 1'b1, LEN_SHORT, 64'd3, 3);
    send_frame(4'h8, OP_PING, 1'b1, LEN_SHORT, 64'd2, 2);
    send_frame(4'h8, 4'hF, 1'b0, LEN_SHORT, 64'd1, 1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = GAP_TAB[ph];
      stall_pct = STALL_TAB[ph];
      // Early in the unpaced phase the result side holds off long enough to fill the block.
      if (ph == 0) hold_ask++;
      target = useful_bytes + PHASE_BYTES;
      while (useful_bytes < target) send_random_frame();
      wait_drained();
    end

    // The link can close only once per run, so the tail of the stream varies.
    tail = stream_tail_e'($urandom_range(2));
    case (tail)
      END_EMPTY_CLOSE:
        send_frame(4'($urandom), OP_CLOSE, 1'($urandom), LEN_SHORT, 64'd0, 0);
      END_CLOSE_WITH_BODY: begin
        target = $urandom_range(6, 1);
        send_frame(4'($urandom), OP_CLOSE, 1'($urandom), LEN_SHORT, 64'(target), target);
      end
      default: begin
        huge_len = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(4'($urandom), OP_PING, 1'b1, LEN_EXT64, huge_len, 30);
      end
    endcase
    if (tail != END_OPEN_FRAME) begin
      for (int i = 0; i < 12; i++) send_byte(8'($urandom));
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d frames over four pacing phases; %0d results compared.",
             total_bytes, frames_sent, results_checked);
    $display("Stream tail: %s, with a long result hold-off and drained pauses.", tail.name());
    if (fail_count == 0) begin
      $display("websocket_frame_decoder verification clean");
    end else begin
      $display("websocket_frame_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timed out with %0d results still owed.", results_owed);
    $display("websocket_frame_decoder verification failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/wsfd_pkg.sv
src/wsfd_channels.sv
src/wsfd_front.sv
src/wsfd_queue.sv
src/wsfd_back.sv
src/websocket_frame_decoder.sv
tb/wsfd_stream_checker.sv
tb/websocket_frame_decoder_tb.sv
